[design/pbro_pkg.sv]
// Shared codes and field widths for the pinned buffer replacement order block.
// No dependencies; imported by the top level.
package pbro_pkg;

    // Stream field widths
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEW    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNPIN_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_VICTIM_PIN = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SATURATED  = 2'd3;

endpackage

[design/pinned_buffer_replacement_order.sv]
// Top level of the pinned buffer replacement order block.
// Uses pbro_pkg, pbro_ram (link and count stores) and pbro_order (reinit sweep).
//
// Usage:
//   One command word enters on s_tvalid/s_tready; exactly one result word leaves
//   on m_tvalid/m_tready for each command. Commands are handled one at a time.
//   s_tready is high while the sequencer is idle, even if a result still waits
//   in the output register; the next command finishes only once that result
//   has been taken, so a stalled receiver stalls the input after one command.
//   Each command runs dependent read/write steps on the three link/count RAMs
//   (one read port each, registered read): pin / pin_new skip the relink at
//   the tail; unpin either leaves the order alone, moves the slot to the head
//   or inserts it after the boundary; reinit writes one slot per cycle.
//   Slot numbers of SLOTS or more are reduced by repeated subtraction.
//   Reset clears head, tail and boundary and the control state; the RAMs hold
//   no defined contents until the first reinit, which must come before any
//   pin or unpin.
module pinned_buffer_replacement_order
    import pbro_pkg::*;
#(
    parameter int SLOTS       = 64,
    parameter int COUNT_WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [1:0] cmd, [7:2] slot
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [5:0] result_slot, [7:6] status
);

    localparam int SW   = $clog2(SLOTS);
    localparam int CW   = COUNT_WIDTH;
    localparam int HALF = SLOTS / 2;
    localparam logic [CW-1:0] MAXC = {CW{1'b1}};

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RED   = 4'd1;
    localparam logic [3:0] ST_ISSUE = 4'd2;
    localparam logic [3:0] ST_LOAD  = 4'd3;
    localparam logic [3:0] ST_DET   = 4'd4;
    localparam logic [3:0] ST_APP   = 4'd5;
    localparam logic [3:0] ST_PRE   = 4'd6;
    localparam logic [3:0] ST_RDB   = 4'd7;
    localparam logic [3:0] ST_LDB   = 4'd8;
    localparam logic [3:0] ST_W4    = 4'd9;
    localparam logic [3:0] ST_SWEEP = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    // what follows the detach step
    localparam logic [1:0] MODE_APP = 2'd0;
    localparam logic [1:0] MODE_PRE = 2'd1;
    localparam logic [1:0] MODE_RDB = 2'd2;

    logic [3:0]          state_reg;
    logic [1:0]          mode_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [SLOT_W-1:0]   red_reg;
    logic [SW-1:0]       s_reg, p_reg, n_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SW-1:0]       head_reg, tail_reg, bnd_reg;
    logic                bvalid_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic                nxt_we, prv_we, cnt_we;
    logic [SW-1:0]       nxt_waddr, prv_waddr, cnt_waddr;
    logic [SW-1:0]       nxt_wdata, prv_wdata;
    logic [CW-1:0]       cnt_wdata;
    logic [SW-1:0]       rd_addr;
    logic [SW-1:0]       nxt_q, prv_q;
    logic [CW-1:0]       cnt_q;

    logic                red_big;
    logic [SW-1:0]       slot_w, center;
    logic                ord_start, ord_step, ord_first, ord_last;
    logic [SW-1:0]       ord_prev, ord_cur, ord_next;
    logic                out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = ~m_tvalid_reg | m_tready;

    // slot reduction and reinit center
    assign red_big = (32'(red_reg) >= SLOTS);
    assign slot_w  = SW'(red_reg);
    assign center  = (slot_w >= SW'(HALF)) ? slot_w - SW'(HALF) : slot_w + SW'(HALF);

    assign ord_start = (state_reg == ST_RED) && !red_big && (cmd_reg == CMD_REINIT);
    assign ord_step  = (state_reg == ST_SWEEP);

    // one read address shared by all stores
    assign rd_addr = (state_reg == ST_RDB) ? bnd_reg : s_reg;

    // store write ports
    always_comb begin
        nxt_we    = 1'b0;
        nxt_waddr = s_reg;
        nxt_wdata = '0;
        prv_we    = 1'b0;
        prv_waddr = s_reg;
        prv_wdata = '0;
        cnt_we    = 1'b0;
        cnt_waddr = s_reg;
        cnt_wdata = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (cmd_reg == CMD_PIN) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = (cnt_q == MAXC) ? MAXC : cnt_q + 1'b1;
                end else if (cmd_reg == CMD_NEW) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = CW'(1);
                end else if (cmd_reg == CMD_UNPIN && cnt_q != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_q - 1'b1;
                end
            end
            ST_DET: begin
                if (s_reg != head_reg && s_reg != tail_reg) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = p_reg;
                    nxt_wdata = n_reg;
                    prv_we    = 1'b1;
                    prv_waddr = n_reg;
                    prv_wdata = p_reg;
                end
            end
            ST_APP: begin
                nxt_we    = 1'b1;
                nxt_waddr = tail_reg;
                nxt_wdata = s_reg;
                prv_we    = 1'b1;
                prv_wdata = tail_reg;
            end
            ST_PRE: begin
                prv_we    = 1'b1;
                prv_waddr = head_reg;
                prv_wdata = s_reg;
                nxt_we    = 1'b1;
                nxt_wdata = head_reg;
            end
            ST_LDB: begin
                nxt_we    = 1'b1;
                nxt_wdata = nxt_q;
                prv_we    = 1'b1;
                prv_waddr = nxt_q;
                prv_wdata = s_reg;
            end
            ST_W4: begin
                nxt_we    = 1'b1;
                nxt_waddr = bnd_reg;
                nxt_wdata = s_reg;
                prv_we    = 1'b1;
                prv_wdata = bnd_reg;
            end
            ST_SWEEP: begin
                nxt_we    = 1'b1;
                nxt_waddr = ord_cur;
                nxt_wdata = ord_last ? '0 : ord_next;
                prv_we    = 1'b1;
                prv_waddr = ord_cur;
                prv_wdata = ord_first ? '0 : ord_prev;
                cnt_we    = 1'b1;
                cnt_waddr = ord_cur;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            bnd_reg      <= '0;
            bvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg    <= s_tdata[CMD_W-1:0];
                        red_reg    <= s_tdata[CMD_W +: SLOT_W];
                        status_reg <= STAT_OK;
                        state_reg  <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (red_big) begin
                        red_reg <= red_reg - SLOT_W'(SLOTS);
                    end else if (cmd_reg == CMD_REINIT) begin
                        s_reg     <= slot_w;
                        head_reg  <= center;
                        state_reg <= ST_SWEEP;
                    end else begin
                        s_reg     <= (cmd_reg == CMD_NEW) ? head_reg : slot_w;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    p_reg <= prv_q;
                    n_reg <= nxt_q;
                    if (cmd_reg == CMD_UNPIN) begin
                        if (cnt_q == '0) begin
                            status_reg <= STAT_UNPIN_ZERO;
                            state_reg  <= ST_DONE;
                        end else if (cnt_q != CW'(1)) begin
                            state_reg <= ST_DONE;
                        end else if (!bvalid_reg) begin
                            bnd_reg    <= s_reg;
                            bvalid_reg <= 1'b1;
                            mode_reg   <= MODE_PRE;
                            state_reg  <= (s_reg != head_reg) ? ST_DET : ST_DONE;
                        end else if (bnd_reg != s_reg) begin
                            mode_reg  <= MODE_RDB;
                            state_reg <= ST_DET;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        mode_reg <= MODE_APP;
                        if (cmd_reg == CMD_NEW) begin
                            if (cnt_q != '0) begin
                                status_reg <= STAT_VICTIM_PIN;
                            end
                        end else if (cnt_q == MAXC) begin
                            status_reg <= STAT_SATURATED;
                        end
                        // pinning the boundary steps it back by one, or clears it at the head
                        if (bvalid_reg && bnd_reg == s_reg) begin
                            if (s_reg == head_reg) begin
                                bvalid_reg <= 1'b0;
                            end else begin
                                bnd_reg <= prv_q;
                            end
                        end
                        state_reg <= (s_reg == tail_reg) ? ST_DONE : ST_DET;
                    end
                end
                ST_DET: begin
                    if (s_reg == head_reg) begin
                        head_reg <= n_reg;
                    end else if (s_reg == tail_reg) begin
                        tail_reg <= p_reg;
                    end
                    unique case (mode_reg)
                        MODE_APP: state_reg <= ST_APP;
                        MODE_PRE: state_reg <= ST_PRE;
                        default:  state_reg <= ST_RDB;
                    endcase
                end
                ST_APP: begin
                    tail_reg <= s_reg;
                    if (cmd_reg == CMD_UNPIN) begin
                        bnd_reg <= s_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_PRE: begin
                    head_reg  <= s_reg;
                    state_reg <= ST_DONE;
                end
                ST_RDB: begin
                    state_reg <= (bnd_reg == tail_reg) ? ST_APP : ST_LDB;
                end
                ST_LDB: begin
                    state_reg <= ST_W4;
                end
                ST_W4: begin
                    bnd_reg   <= s_reg;
                    state_reg <= ST_DONE;
                end
                ST_SWEEP: begin
                    if (ord_last) begin
                        tail_reg   <= s_reg;
                        bnd_reg    <= s_reg;
                        bvalid_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {status_reg, SLOT_W'(s_reg)};
        end
    end

    pbro_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
        .aclk  (aclk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_q)
    );

    pbro_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_ram (
        .aclk  (aclk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_q)
    );

    pbro_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (rd_addr),
        .rdata (cnt_q)
    );

    pbro_order #(.SLOTS(SLOTS)) u_order (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ord_start),
        .center    (center),
        .step      (ord_step),
        .prev_slot (ord_prev),
        .cur_slot  (ord_cur),
        .next_slot (ord_next),
        .first     (ord_first),
        .last      (ord_last)
    );

endmodule

[design/pbro_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pbro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port, read data registered (old data on same-cycle collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/pbro_order.sv]
// Reinit order generator: center, center-1, center+1, center-2, ... (mod SLOTS).
// Produces previous, current and next slot of the sweep. No dependencies.
module pbro_order #(
    parameter int SLOTS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [$clog2(SLOTS)-1:0] center,
    input  logic                     step,
    output logic [$clog2(SLOTS)-1:0] prev_slot,
    output logic [$clog2(SLOTS)-1:0] cur_slot,
    output logic [$clog2(SLOTS)-1:0] next_slot,
    output logic                     first,
    output logic                     last
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] TOP = SW'(SLOTS - 1);

    logic [SW-1:0] prev_reg, cur_reg, dn_reg, up_reg, idx_reg;
    logic          take_dn;

    function automatic logic [SW-1:0] dec_wrap(input logic [SW-1:0] x);
        return (x == '0) ? TOP : x - 1'b1;
    endfunction

    function automatic logic [SW-1:0] inc_wrap(input logic [SW-1:0] x);
        return (x == TOP) ? '0 : x + 1'b1;
    endfunction

    // odd positions step down from the center, even positions step up
    assign take_dn   = ~idx_reg[0];
    assign next_slot = take_dn ? dn_reg : up_reg;
    assign prev_slot = prev_reg;
    assign cur_slot  = cur_reg;
    assign first     = (idx_reg == '0);
    assign last      = (idx_reg == TOP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (start) begin
            idx_reg <= '0;
        end else if (step) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prev_reg <= '0;
            cur_reg  <= center;
            dn_reg   <= dec_wrap(center);
            up_reg   <= inc_wrap(center);
        end else if (step) begin
            prev_reg <= cur_reg;
            cur_reg  <= next_slot;
            if (take_dn) begin
                dn_reg <= dec_wrap(dn_reg);
            end else begin
                up_reg <= inc_wrap(up_reg);
            end
        end
    end

endmodule

[sim/tb.sv]
// Self-checking bench for pinned_buffer_replacement_order: drives command words,
// predicts replacement order, pin counts and boundary, checks every result word.
// Depends on design/pbro_pkg.sv and design/pinned_buffer_replacement_order.sv.
`timescale 1ns / 100ps

module tb;
    import pbro_pkg::*;

    localparam int NSLOT = 64;
    localparam int MAXC  = 255;

    // Scoreboard: own copy of order, counts and boundary
    class order_scoreboard;
        int nxt[NSLOT];
        int prv[NSLOT];
        int cnt[NSLOT];
        int head_s, tail_s, bnd_s;
        bit bnd_ok;
        logic [OUT_W-1:0] result_q[$];
        int errors;
        int checked;
        int cmd_seen[4];
        int stat_seen[4];

        function void unlink(int s);
            int p, n;
            if (s == head_s) begin
                head_s = nxt[s];
            end else if (s == tail_s) begin
                tail_s = prv[s];
            end else begin
                p = prv[s];
                n = nxt[s];
                nxt[p] = n;
                prv[n] = p;
            end
        endfunction

        function void to_tail(int s);
            nxt[tail_s] = s;
            prv[s] = tail_s;
            tail_s = s;
        endfunction

        function void reorder(int start);
            int center, i, a, b;
            center = (start + NSLOT / 2) % NSLOT;
            head_s = center;
            a = center;
            for (i = 0; i < NSLOT; i++) cnt[i] = 0;
            for (i = 1; i < NSLOT; i++) begin
                if (i == NSLOT - 1) b = (center + NSLOT / 2) % NSLOT;
                else if (i % 2 == 1) b = (center + NSLOT - (i + 1) / 2) % NSLOT;
                else b = (center + i / 2) % NSLOT;
                nxt[a] = b;
                prv[b] = a;
                a = b;
            end
            tail_s = a;
            bnd_s = a;
            bnd_ok = 1;
        endfunction

        // Work out the result of one accepted command word
        function void predict_command(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] sl);
            int s, res, n, b;
            logic [STATUS_W-1:0] st;
            s = sl;
            res = s;
            st = STAT_OK;
            case (c)
                CMD_REINIT: reorder(s);
                CMD_PIN: begin
                    if (bnd_ok && bnd_s == s) begin
                        if (s == head_s) bnd_ok = 0;
                        else bnd_s = prv[s];
                    end
                    if (s != tail_s) begin
                        unlink(s);
                        to_tail(s);
                    end
                    if (cnt[s] >= MAXC) begin
                        cnt[s] = MAXC;
                        st = STAT_SATURATED;
                    end else begin
                        cnt[s]++;
                    end
                end
                CMD_NEW: begin
                    res = head_s;
                    if (bnd_ok && bnd_s == res) bnd_ok = 0;
                    if (cnt[res] != 0) st = STAT_VICTIM_PIN;
                    if (res != tail_s) begin
                        unlink(res);
                        to_tail(res);
                    end
                    cnt[res] = 1;
                end
                default: begin
                    if (cnt[s] == 0) begin
                        st = STAT_UNPIN_ZERO;
                    end else begin
                        cnt[s]--;
                        if (cnt[s] == 0) begin
                            if (!bnd_ok) begin
                                bnd_s = s;
                                bnd_ok = 1;
                                if (s != head_s) begin
                                    unlink(s);
                                    prv[head_s] = s;
                                    nxt[s] = head_s;
                                    head_s = s;
                                end
                            end else if (bnd_s != s) begin
                                b = bnd_s;
                                unlink(s);
                                if (b == tail_s) begin
                                    to_tail(s);
                                end else begin
                                    n = nxt[b];
                                    nxt[s] = n;
                                    prv[n] = s;
                                    nxt[b] = s;
                                    prv[s] = b;
                                end
                                bnd_s = s;
                            end
                        end
                    end
                end
            endcase
            cmd_seen[c]++;
            result_q.push_back({st, res[SLOT_W-1:0]});
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(logic [OUT_W-1:0] d);
            logic [OUT_W-1:0] e;
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = result_q.pop_front();
            checked++;
            stat_seen[e[7:6]]++;
            if (d[5:0] !== e[5:0] || d[7:6] !== e[7:6]) begin
                errors++;
                if (errors <= 10)
                    $display("word %0d: slot exp %0d got %0d, status exp %0d got %0d",
                             checked, e[5:0], d[5:0], e[7:6], d[7:6]);
            end
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;

    order_scoreboard sb = new();
    bit hold_req = 0;

    pinned_buffer_replacement_order u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Offer one word and wait until it is taken; valid stays high afterward
    task automatic send_word(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] sl);
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {sl, c};
        do @(posedge aclk); while (!s_tready);
        sb.predict_command(c, sl);
    endtask

    task automatic go_idle(int n);
        @(negedge aclk);
        s_tvalid <= 0;
        repeat (n) @(negedge aclk);
    endtask

    // Pick slots mostly from a small hot set so counts come back to zero
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(1, 0)) return SLOT_W'($urandom_range(7, 0));
        return SLOT_W'($urandom_range(63, 0));
    endfunction

    // Receiver: stall pattern redrawn from four modes, plus one long hold-off
    initial begin : receiver
        int mode, hold, k;
        bit held;
        hold = 0;
        k = 0;
        mode = 0;
        held = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held && hold == 0 && k >= 0) begin
                hold = 400;
                held = 1;
                k = -1;
            end
            if (k % 64 == 0) mode = $urandom_range(3, 0);
            if (k >= 0) k++;
            if (hold > 0) begin
                hold--;
                m_tready <= 0;
                if (hold == 0) k = 1;
            end else begin
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= $urandom_range(1, 0);
                    2: m_tready <= ($urandom_range(3, 0) == 0);
                    default: m_tready <= ($urandom_range(7, 0) != 0);
                endcase
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Stimulus
    initial begin : stimulus
        int i, burst, r;
        logic [CMD_W-1:0] c;
        repeat (12) @(negedge aclk);
        aresetn <= 1;

        // Directed: order extremes, boundary moves, zero-count unpin
        send_word(CMD_REINIT, 6'd0);
        send_word(CMD_REINIT, 6'd63);
        send_word(CMD_REINIT, 6'd32);
        send_word(CMD_UNPIN, 6'd5);
        send_word(CMD_PIN, 6'd32);
        send_word(CMD_PIN, 6'd31);
        send_word(CMD_NEW, 6'd0);
        send_word(CMD_NEW, 6'd63);
        send_word(CMD_PIN, 6'd63);
        send_word(CMD_PIN, 6'd63);
        send_word(CMD_UNPIN, 6'd63);
        send_word(CMD_UNPIN, 6'd63);
        send_word(CMD_UNPIN, 6'd31);
        send_word(CMD_UNPIN, 6'd32);
        send_word(CMD_UNPIN, 6'd0);
        send_word(CMD_PIN, 6'd42);
        send_word(CMD_UNPIN, 6'd42);
        // victims wrap around to pinned slots
        for (i = 0; i < 70; i++) send_word(CMD_NEW, 6'd0);
        send_word(CMD_UNPIN, 6'd0);
        // count saturation
        for (i = 0; i < 258; i++) send_word(CMD_PIN, 6'd21);
        send_word(CMD_REINIT, 6'd1);

        // Random bursts with gaps
        burst = 0;
        for (i = 0; i < 1100; i++) begin
            if (burst == 0) begin
                go_idle($urandom_range(8, 0));
                burst = ($urandom_range(9, 0) == 0) ? 60 : $urandom_range(20, 1);
            end
            burst--;
            if (i == 400) hold_req = 1;
            if (i == 700) begin
                go_idle(1);
                while (sb.result_q.size() != 0) @(negedge aclk);
            end
            r = $urandom_range(99, 0);
            if (r < 2) c = CMD_REINIT;
            else if (r < 40) c = CMD_PIN;
            else if (r < 62) c = CMD_NEW;
            else c = CMD_UNPIN;
            send_word(c, (c == CMD_REINIT) ? SLOT_W'($urandom_range(63, 0)) : pick_slot());
        end
        go_idle(0);

        while (sb.result_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.result_q.size() != 0) sb.errors++;
        $display("covered %0d reinit, %0d pin, %0d pin_new, %0d unpin commands",
                 sb.cmd_seen[CMD_REINIT], sb.cmd_seen[CMD_PIN],
                 sb.cmd_seen[CMD_NEW], sb.cmd_seen[CMD_UNPIN]);
        $display("statuses ok %0d, zero unpin %0d, pinned victim %0d, saturated %0d",
                 sb.stat_seen[STAT_OK], sb.stat_seen[STAT_UNPIN_ZERO],
                 sb.stat_seen[STAT_VICTIM_PIN], sb.stat_seen[STAT_SATURATED]);
        if (sb.errors == 0) begin
            $display("pinned_buffer_replacement_order: match");
        end else begin
            $display("pinned_buffer_replacement_order: mismatch");
        end
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #5000000;
        $display("pinned_buffer_replacement_order: mismatch");
        $finish;
    end

endmodule
